// ===== hw/rtl/scc_pkg.sv =====
// ============================================================================
// scc_pkg: shared definitions for the strong connectivity checker
// Widths, commands, walk sequencer states and the result record.
// ============================================================================
package scc_pkg;

    localparam int ROW_W                = 32;
    localparam int VIDX_W               = 5;
    localparam int VCNT_W               = 6;
    localparam int DEFAULT_MAX_VERTICES = 32;
    localparam int S_TDATA_W            = 48;
    localparam int M_TDATA_W            = 72;

    localparam logic [VCNT_W-1:0] VERTEX_COUNT_RESET = 6'd32;

    localparam logic CMD_LOAD  = 1'b0;
    localparam logic CMD_CHECK = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_FWD_PICK,
        ST_FWD_WAIT,
        ST_REV_SWEEP,
        ST_DONE
    } scc_state_t;

    typedef struct packed {
        logic              strongly_connected;
        logic [ROW_W-1:0]  reverse_reached;
        logic [ROW_W-1:0]  forward_reached;
    } scc_result_t;

endpackage

// ===== hw/rtl/scc_adj_mem.sv =====
// ============================================================================
// scc_adj_mem: adjacency row memory
// One write port, one registered read port; rows never written read as zero.
// ============================================================================
module scc_adj_mem #(
    parameter int DEPTH = scc_pkg::DEFAULT_MAX_VERTICES,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     wr_en,
    input  logic [AW-1:0]            wr_addr,
    input  logic [scc_pkg::ROW_W-1:0] wr_data,
    input  logic                     rd_en,
    input  logic [AW-1:0]            rd_addr,
    output logic [scc_pkg::ROW_W-1:0] rd_data
);
    import scc_pkg::*;

    logic [ROW_W-1:0] adj_mem_reg [DEPTH];
    logic [DEPTH-1:0] valid_reg;
    logic [DEPTH-1:0] valid_next;
    logic [ROW_W-1:0] rd_data_reg;
    logic             rd_valid_reg;

    always_comb begin
        valid_next = valid_reg;
        if (wr_en) begin
            valid_next[wr_addr] = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            adj_mem_reg[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg  <= adj_mem_reg[rd_addr];
            rd_valid_reg <= valid_reg[rd_addr];
        end
    end

    assign rd_data = rd_valid_reg ? rd_data_reg : '0;

endmodule

// ===== hw/rtl/scc_walk.sv =====
// ============================================================================
// scc_walk: forward and reverse reachability sequencer
// Forward walk expands one pending vertex per row read; the reverse walk
// sweeps all active rows until a sweep adds nothing.
// ============================================================================
module scc_walk #(
    parameter int AW = $clog2(scc_pkg::DEFAULT_MAX_VERTICES)
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       start,
    input  logic [scc_pkg::VIDX_W-1:0] start_vertex,
    input  logic [scc_pkg::VCNT_W-1:0] active_n,
    input  logic [scc_pkg::ROW_W-1:0]  active_mask,
    input  logic                       out_free,
    input  logic [scc_pkg::ROW_W-1:0]  rd_row,
    output logic                       rd_en,
    output logic [AW-1:0]              rd_addr,
    output logic                       idle,
    output logic                       done,
    output scc_pkg::scc_result_t       result
);
    import scc_pkg::*;

    localparam int EXT_W = (AW > VCNT_W) ? AW : VCNT_W;

    scc_state_t        state_reg, state_next;
    logic [ROW_W-1:0]  reach_reg, reach_next;
    logic [ROW_W-1:0]  pend_reg, pend_next;
    logic [ROW_W-1:0]  fwd_reg, fwd_next;
    logic [VIDX_W-1:0] start_reg, start_next;
    logic              oor_reg, oor_next;
    logic [VCNT_W-1:0] idx_reg, idx_next;
    logic              proc_valid_reg, proc_valid_next;
    logic [VIDX_W-1:0] proc_idx_reg, proc_idx_next;
    logic              changed_reg, changed_next;

    logic [ROW_W-1:0]  pend_low;
    logic [VIDX_W-1:0] pick_idx;
    logic [ROW_W-1:0]  row_act;
    logic [ROW_W-1:0]  start_onehot;
    logic              start_ok;
    logic              sweep_issue;
    logic              sweep_end;
    logic [EXT_W-1:0]  addr_ext;

    // Lowest pending vertex.
    always_comb begin
        pend_low = pend_reg & (~pend_reg + ROW_W'(1));
        pick_idx = '0;
        for (int i = 0; i < ROW_W; i++) begin
            if (pend_low[i]) begin
                pick_idx = pick_idx | VIDX_W'(i);
            end
        end
    end

    assign row_act      = rd_row & active_mask;
    assign start_onehot = ROW_W'(1) << start_vertex;
    assign start_ok     = {1'b0, start_vertex} < active_n;
    assign sweep_issue  = idx_reg < active_n;
    assign sweep_end    = !sweep_issue && !proc_valid_reg;

    // Next state.
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (start) begin
                    state_next = start_ok ? ST_FWD_PICK : ST_DONE;
                end
            end
            ST_FWD_PICK: begin
                state_next = (pend_reg == '0) ? ST_REV_SWEEP : ST_FWD_WAIT;
            end
            ST_FWD_WAIT: begin
                state_next = ST_FWD_PICK;
            end
            ST_REV_SWEEP: begin
                if (sweep_end && !changed_reg) begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // Datapath.
    always_comb begin
        reach_next      = reach_reg;
        pend_next       = pend_reg;
        fwd_next        = fwd_reg;
        start_next      = start_reg;
        oor_next        = oor_reg;
        idx_next        = idx_reg;
        proc_valid_next = 1'b0;
        proc_idx_next   = proc_idx_reg;
        changed_next    = changed_reg;
        case (state_reg)
            ST_IDLE: begin
                if (start) begin
                    start_next = start_vertex;
                    oor_next   = !start_ok;
                    reach_next = start_ok ? start_onehot : '0;
                    pend_next  = start_ok ? start_onehot : '0;
                    fwd_next   = '0;
                end
            end
            ST_FWD_PICK: begin
                if (pend_reg == '0) begin
                    fwd_next     = reach_reg;
                    reach_next   = ROW_W'(1) << start_reg;
                    idx_next     = '0;
                    changed_next = 1'b0;
                end else begin
                    pend_next = pend_reg & ~pend_low;
                end
            end
            ST_FWD_WAIT: begin
                reach_next = reach_reg | row_act;
                pend_next  = pend_reg | (row_act & ~reach_reg);
            end
            ST_REV_SWEEP: begin
                if (sweep_issue) begin
                    idx_next        = idx_reg + VCNT_W'(1);
                    proc_valid_next = 1'b1;
                    proc_idx_next   = idx_reg[VIDX_W-1:0];
                end
                if (proc_valid_reg && !reach_reg[proc_idx_reg]
                        && ((row_act & reach_reg) != '0)) begin
                    reach_next[proc_idx_reg] = 1'b1;
                    changed_next             = 1'b1;
                end
                if (sweep_end) begin
                    idx_next     = '0;
                    changed_next = 1'b0;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            proc_valid_reg <= 1'b0;
        end else begin
            state_reg      <= state_next;
            proc_valid_reg <= proc_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        reach_reg    <= reach_next;
        pend_reg     <= pend_next;
        fwd_reg      <= fwd_next;
        start_reg    <= start_next;
        oor_reg      <= oor_next;
        idx_reg      <= idx_next;
        proc_idx_reg <= proc_idx_next;
        changed_reg  <= changed_next;
    end

    // Outputs.
    always_comb begin
        rd_en    = 1'b0;
        addr_ext = '0;
        idle     = 1'b0;
        done     = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                idle = 1'b1;
            end
            ST_FWD_PICK: begin
                rd_en    = pend_reg != '0;
                addr_ext = EXT_W'(pick_idx);
            end
            ST_FWD_WAIT: begin
            end
            ST_REV_SWEEP: begin
                rd_en    = sweep_issue;
                addr_ext = EXT_W'(idx_reg);
            end
            ST_DONE: begin
                done = out_free;
            end
            default: begin
            end
        endcase
        rd_addr = addr_ext[AW-1:0];
    end

    assign result.forward_reached    = fwd_reg;
    assign result.reverse_reached    = reach_reg;
    assign result.strongly_connected = !oor_reg && (fwd_reg == active_mask)
                                       && (reach_reg == active_mask);

endmodule

// ===== hw/rtl/strong_connectivity_check.sv =====
// ============================================================================
// strong_connectivity_check: directed graph strong connectivity checker
// Holds an adjacency bit matrix and checks reachability both ways from a vertex.
// ============================================================================
// A row load produces no result transaction. A check walks forward, reading one row
// per vertex reached forward, then makes reverse sweeps over the active rows until a
// sweep adds nothing (at most n sweeps, n the active vertex count); every step is
// bound by the single memory read port. A start vertex out of range skips both walks
// and goes straight to the done state. One item is in flight. Reset empties the
// matrix (no edges) and sets the vertex count to 32.
module strong_connectivity_check #(
    parameter int MAX_VERTICES = scc_pkg::DEFAULT_MAX_VERTICES
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    // Vertex count register write.
    input  logic                           cfg_we,
    input  logic [scc_pkg::VCNT_W-1:0]     cfg_wdata,
    // Input stream.
    input  logic                           s_tvalid,
    output logic                           s_tready,
    // Bits from the lowest up: row_index[4:0], row_bits[36:5],
    // start_vertex[41:37], zero padding[47:42].
    input  logic [scc_pkg::S_TDATA_W-1:0]  s_tdata,
    // Bit 0: command (0 loads a row, 1 runs a check).
    input  logic [0:0]                     s_tuser,
    // Result stream.
    output logic                           m_tvalid,
    input  logic                           m_tready,
    // Bits from the lowest up: forward_reached[31:0], reverse_reached[63:32],
    // strongly_connected[64], zero padding[71:65].
    output logic [scc_pkg::M_TDATA_W-1:0]  m_tdata
);
    import scc_pkg::*;

    // Address width of the row memory, and the largest usable vertex count.
    localparam int AW    = $clog2(MAX_VERTICES);
    localparam int VCAP  = (MAX_VERTICES < ROW_W) ? MAX_VERTICES : ROW_W;
    localparam int IDX_W = (AW > VIDX_W) ? AW + 1 : VIDX_W + 1;

    logic [VCNT_W-1:0]    vertex_count_reg;
    logic                 m_tvalid_reg;
    logic [M_TDATA_W-1:0] m_tdata_reg;

    logic [VIDX_W-1:0]    row_index;
    logic [ROW_W-1:0]     row_bits;
    logic [VIDX_W-1:0]    start_vertex;
    logic                 in_accept;
    logic                 load_accept;
    logic                 check_accept;
    logic [IDX_W-1:0]     row_index_ext;
    logic                 row_in_range;

    logic [VCNT_W-1:0]    active_n;
    logic [ROW_W:0]       active_shift;
    logic [ROW_W-1:0]     active_mask;

    logic                 rd_en;
    logic [AW-1:0]        rd_addr;
    logic [ROW_W-1:0]     rd_row;
    logic                 walk_idle;
    logic                 walk_done;
    logic                 out_free;
    scc_result_t          walk_result;

    // Unpack the input transaction.
    assign row_index    = s_tdata[VIDX_W-1:0];
    assign row_bits     = s_tdata[VIDX_W +: ROW_W];
    assign start_vertex = s_tdata[VIDX_W + ROW_W +: VIDX_W];

    // New items are taken only while the walk sequencer is idle. A result that
    // still waits in the output register does not block row loads; a check
    // simply holds its answer until the register frees up.
    assign s_tready     = walk_idle;
    assign in_accept    = s_tvalid && s_tready;
    assign load_accept  = in_accept && (s_tuser[0] == CMD_LOAD);
    assign check_accept = in_accept && (s_tuser[0] == CMD_CHECK);

    // Loads beyond the matrix depth are dropped.
    assign row_index_ext = IDX_W'(row_index);
    assign row_in_range  = row_index_ext < IDX_W'(MAX_VERTICES);

    // The active vertex count saturates at the matrix size, and the active
    // mask covers vertices 0 to n-1 (empty for a count of zero).
    assign active_n     = (vertex_count_reg > VCNT_W'(VCAP)) ? VCNT_W'(VCAP)
                                                              : vertex_count_reg;
    assign active_shift = (ROW_W + 1)'(1) << active_n;
    assign active_mask  = ROW_W'(active_shift - (ROW_W + 1)'(1));

    // The user may only change the vertex count register while the block is idle; the block itself does not enforce it.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vertex_count_reg <= VERTEX_COUNT_RESET;
        end else if (cfg_we) begin
            vertex_count_reg <= cfg_wdata;
        end
    end

    scc_adj_mem #(
        .DEPTH (MAX_VERTICES),
        .AW    (AW)
    ) u_adj_mem (
        .aclk    (aclk),
        .aresetn (aresetn),
        .wr_en   (load_accept && row_in_range),
        .wr_addr (row_index_ext[AW-1:0]),
        .wr_data (row_bits),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_row)
    );

    scc_walk #(
        .AW (AW)
    ) u_walk (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .start        (check_accept),
        .start_vertex (start_vertex),
        .active_n     (active_n),
        .active_mask  (active_mask),
        .out_free     (out_free),
        .rd_row       (rd_row),
        .rd_en        (rd_en),
        .rd_addr      (rd_addr),
        .idle         (walk_idle),
        .done         (walk_done),
        .result       (walk_result)
    );

    // Output register: it is free when empty or when its transaction
    // completes in this cycle.
    assign out_free = !m_tvalid_reg || m_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (walk_done) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (walk_done) begin
            m_tdata_reg <= M_TDATA_W'(walk_result);
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

endmodule

// ===== tb/sv/strong_connectivity_check_tb.sv =====
`timescale 1ns / 1ps
// ============================================================================
// strong_connectivity_check_tb: self-checking bench for the connectivity checker
// Loads random directed graphs row by row, runs forward and reverse reachability
// checks from random start vertices under several vertex counts, and compares
// every result transaction against a software model of both walks.
// ============================================================================

import scc_pkg::*;

class reach_scoreboard;
    logic [ROW_W-1:0]  adjacency [32];
    logic [VCNT_W-1:0] vertex_count;
    scc_result_t       expected_reach [$];
    int                mismatch_count;

    function new();
        foreach (adjacency[i]) adjacency[i] = '0;
        vertex_count   = VERTEX_COUNT_RESET;
        mismatch_count = 0;
    endfunction

    function void set_vertex_count(logic [VCNT_W-1:0] value);
        vertex_count = value;
    endfunction

    function int pending();
        return expected_reach.size();
    endfunction

    function bit failed();
        return (mismatch_count != 0) || (expected_reach.size() != 0);
    endfunction

    // Both walks run breadth first over the active vertices only.
    function scc_result_t predict_reach(logic [VIDX_W-1:0] start);
        int               n;
        logic [ROW_W-1:0] act;
        logic [ROW_W-1:0] reached;
        logic [ROW_W-1:0] frontier;
        logic [ROW_W-1:0] grown;
        scc_result_t      res;
        n   = (vertex_count > 32) ? 32 : int'(vertex_count);
        act = 32'((64'd1 << n) - 64'd1);
        res = '0;
        if (int'(start) >= n) return res;

        reached  = 32'd1 << start;
        frontier = reached;
        for (int r = 0; r < 32 && frontier != 0; r++) begin
            grown = '0;
            for (int v = 0; v < n; v++)
                if (frontier[v]) grown |= adjacency[v] & act;
            grown    &= ~reached;
            reached  |= grown;
            frontier  = grown;
        end
        res.forward_reached = reached;

        reached  = 32'd1 << start;
        frontier = reached;
        for (int r = 0; r < 32 && frontier != 0; r++) begin
            grown = '0;
            for (int u = 0; u < n; u++)
                if (!reached[u] && ((adjacency[u] & act & frontier) != 0)) grown[u] = 1'b1;
            reached  |= grown;
            frontier  = grown;
        end
        res.reverse_reached    = reached;
        res.strongly_connected = (res.forward_reached == act) && (reached == act);
        return res;
    endfunction

    function void note_transaction(logic cmd, logic [S_TDATA_W-1:0] data);
        if (cmd == CMD_LOAD) adjacency[data[4:0]] = data[36:5];
        else expected_reach.push_back(predict_reach(data[41:37]));
    endfunction

    function void note_mismatch(string what);
        mismatch_count++;
        if (mismatch_count <= 10) $display("[%0t] %s", $realtime, what);
    endfunction

    function void check_result(logic [M_TDATA_W-1:0] data);
        scc_result_t got;
        scc_result_t want;
        got = data[64:0];
        if (expected_reach.size() == 0) begin
            note_mismatch($sformatf("Unexpected result: fwd %h rev %h sc %b",
                got.forward_reached, got.reverse_reached, got.strongly_connected));
            return;
        end
        want = expected_reach.pop_front();
        if (got.forward_reached != want.forward_reached ||
            got.reverse_reached != want.reverse_reached ||
            got.strongly_connected != want.strongly_connected)
            note_mismatch($sformatf(
                "Reach mismatch: expected fwd %h rev %h sc %b, got fwd %h rev %h sc %b",
                want.forward_reached, want.reverse_reached, want.strongly_connected,
                got.forward_reached, got.reverse_reached, got.strongly_connected));
    endfunction
endclass

module strong_connectivity_check_tb;

    // The limit on cycles without any transaction leaves a wide margin over the
    // longest check plus a stall.
    localparam int QUIET_LIMIT  = 20000;
    localparam int RANDOM_ITEMS = 1850;
    // Cycles allowed for a row load still in flight once no result is owed.
    localparam int SETTLE_CYCLES = 20;

    typedef enum int {RX_OPEN, RX_COIN, RX_SPARSE, RX_BLOCKS} rx_mode_t;
    typedef enum int {GRAPH_RING, GRAPH_SPARSE, GRAPH_DENSE, GRAPH_PATH,
                      GRAPH_BROKEN_RING} graph_kind_t;

    logic                   aclk      = 1'b0;
    logic                   aresetn   = 1'b0;
    logic                   cfg_we    = 1'b0;
    logic [VCNT_W-1:0]      cfg_wdata = '0;
    logic                   s_tvalid  = 1'b0;
    logic                   s_tready;
    logic [S_TDATA_W-1:0]   s_tdata   = '0;
    logic [0:0]             s_tuser   = '0;
    logic                   m_tvalid;
    logic                   m_tready  = 1'b0;
    logic [M_TDATA_W-1:0]   m_tdata;

    reach_scoreboard sb;
    int              quiet_cycles = 0;
    int              items_sent   = 0;
    int              burst_left   = 8;
    rx_mode_t        rx_mode      = RX_OPEN;
    int              rx_left      = 0;

    strong_connectivity_check dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    always #5 aclk = ~aclk;

    // Receiver back-pressure. When the current pattern's run ends, a new one is
    // chosen at random: always ready, a coin toss, mostly stalled, or regular blocks
    // of stall. The open pattern gives stretches with no stalls at all.
    always @(negedge aclk) begin
        if (rx_left == 0) begin
            rx_mode = rx_mode_t'($urandom_range(0, 3));
            rx_left = $urandom_range(100, 400);
        end
        rx_left--;
        case (rx_mode)
            RX_OPEN:   m_tready <= 1'b1;
            RX_COIN:   m_tready <= 1'($urandom_range(0, 1));
            RX_SPARSE: m_tready <= ($urandom_range(0, 7) == 0);
            default:   m_tready <= ((rx_left % 40) >= 25);
        endcase
    end

    // Both channels are sampled at the rising edge. Accepted input transactions
    // update the model; accepted results are checked against the oldest
    // prediction. The watchdog counts edges with no transaction on either side.
    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_tvalid && s_tready) sb.note_transaction(s_tuser[0], s_tdata);
            if (m_tvalid && m_tready) sb.check_result(m_tdata);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) quiet_cycles = 0;
            else quiet_cycles++;
            if (quiet_cycles >= QUIET_LIMIT) begin
                $display("Testbench completed WITH ERRORS");
                $finish;
            end
        end
    end

    // Sender pacing: bursts of random length separated by random gaps, with
    // an occasional long burst so that back-to-back traffic is also covered.
    task automatic pace();
        int gap;
        if (burst_left > 0) burst_left--;
        if (burst_left == 0) begin
            gap = $urandom_range(1, 12);
            @(negedge aclk);
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
            burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(60, 200)
                                                     : $urandom_range(1, 16);
        end
    endtask

    // Presents one transaction at the falling edge and holds it until the
    // rising edge at which the block accepts it.
    task automatic send_item(logic cmd, logic [VIDX_W-1:0] row, logic [ROW_W-1:0] bits,
                             logic [VIDX_W-1:0] start);
        @(negedge aclk);
        s_tvalid <= 1'b1;
        s_tuser  <= cmd;
        s_tdata  <= {6'd0, start, bits, row};
        forever begin
            @(posedge aclk);
            if (s_tready) break;
        end
        items_sent++;
        pace();
    endtask

    task automatic send_check(logic [VIDX_W-1:0] start);
        send_item(CMD_CHECK, 5'($urandom), $urandom, start);
    endtask

    task automatic send_row(logic [VIDX_W-1:0] row, logic [ROW_W-1:0] bits);
        send_item(CMD_LOAD, row, bits, 5'($urandom));
    endtask

    // Stops the sender until every predicted result has arrived, then lets a
    // trailing row load finish, since a load produces no result to wait for.
    task automatic drain_results();
        @(negedge aclk);
        s_tvalid <= 1'b0;
        while (sb.pending() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    // The vertex count is only changed with the block idle.
    task automatic set_vertex_count(logic [VCNT_W-1:0] value);
        drain_results();
        @(negedge aclk);
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        @(posedge aclk);
        sb.set_vertex_count(value);
        @(negedge aclk);
        cfg_we <= 1'b0;
    endtask

    // An arbitrary transaction dropped into a sequence now and then.
    task automatic maybe_noise();
        if ($urandom_range(0, 19) == 0)
            send_item(1'($urandom), 5'($urandom), $urandom, 5'($urandom));
    endtask

    // One graph episode: build a graph of a random shape over the active
    // vertices, load its rows in shuffled order (sometimes only part of them),
    // then run a few checks, mostly from active start vertices.
    task automatic run_episode(int nn);
        graph_kind_t      kind;
        logic [ROW_W-1:0] act;
        logic [ROW_W-1:0] rows [32];
        int               order [32];
        int               cut;
        int               j;
        int               tmp;
        int               checks;
        logic [VIDX_W-1:0] start;
        act  = 32'((64'd1 << nn) - 64'd1);
        kind = graph_kind_t'($urandom_range(0, 4));
        for (int v = 0; v < 32; v++) begin
            rows[v]  = '0;
            order[v] = v;
        end
        for (int v = 0; v < nn; v++) begin
            case (kind)
                GRAPH_RING, GRAPH_BROKEN_RING:
                    rows[v] = (32'd1 << ((v + 1) % nn)) |
                              (($urandom_range(0, 1) == 0) ? ($urandom & $urandom & $urandom
                                                              & $urandom) : 32'd0);
                GRAPH_SPARSE: rows[v] = $urandom & $urandom & $urandom & $urandom;
                GRAPH_DENSE:  rows[v] = $urandom | $urandom;
                default:      rows[v] = (v + 1 < nn) ? (32'd1 << (v + 1)) : 32'd0;
            endcase
            // Edges to inactive vertices are stored but must never be followed.
            if ($urandom_range(0, 2) == 0) rows[v] |= $urandom & ~act;
        end
        if (kind == GRAPH_BROKEN_RING && nn > 0) rows[$urandom_range(0, nn - 1)] = '0;

        for (int i = nn - 1; i > 0; i--) begin
            j        = $urandom_range(0, i);
            tmp      = order[i];
            order[i] = order[j];
            order[j] = tmp;
        end
        cut = nn;
        if (nn > 0 && $urandom_range(0, 6) == 0) cut = $urandom_range(0, nn);
        for (int i = 0; i < cut; i++) begin
            maybe_noise();
            send_row(5'(order[i]), rows[order[i]]);
        end
        if (nn < 32 && $urandom_range(0, 3) == 0)
            send_row(5'($urandom_range(nn, 31)), $urandom);

        checks = $urandom_range(1, 5);
        repeat (checks) begin
            maybe_noise();
            if (nn > 0 && $urandom_range(0, 4) != 0) start = 5'($urandom_range(0, nn - 1));
            else start = 5'($urandom_range(0, 31));
            send_check(start);
        end
    endtask

    initial begin
        int vc;
        sb = new();
        repeat (11) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // Directed part. An empty graph with all 32 vertices active first,
        // then a hub row with every bit set and a single edge back to vertex 0.
        send_check(5'd0);
        send_check(5'd31);
        send_row(5'd0, 32'hFFFF_FFFF);
        send_row(5'd31, 32'h0000_0001);
        send_check(5'd0);
        send_check(5'd31);
        send_row(5'd17, 32'h8000_0000);
        send_check(5'd17);
        // Two active vertices joined both ways: strongly connected, while
        // starts at or above the count must give empty masks.
        set_vertex_count(6'd2);
        send_row(5'd1, 32'h0000_0001);
        send_check(5'd0);
        send_check(5'd1);
        send_check(5'd2);
        send_check(5'd31);
        // No active vertex at all, so every start is out of range.
        set_vertex_count(6'd0);
        send_check(5'd0);
        // A count above 32 behaves as 32.
        set_vertex_count(6'd63);
        send_check(5'd0);
        // A single vertex is trivially strongly connected.
        set_vertex_count(6'd1);
        send_check(5'd0);
        send_row(5'd31, 32'h0000_0000);
        set_vertex_count(6'd33);
        send_check(5'd31);

        // Random part: phases of one vertex count each, every phase a few
        // graph episodes. The drain before each count change is also the
        // point at which the sender pauses until all results are in.
        items_sent = 0;
        while (items_sent < RANDOM_ITEMS) begin
            case ($urandom_range(0, 9))
                0:       vc = 0;
                1:       vc = 1;
                2:       vc = 2;
                3:       vc = 32;
                4:       vc = $urandom_range(33, 63);
                default: vc = $urandom_range(1, 32);
            endcase
            set_vertex_count(6'(vc));
            repeat ($urandom_range(1, 4)) run_episode((vc > 32) ? 32 : vc);
        end

        drain_results();
        repeat (50) @(posedge aclk);
        if (sb.failed()) $display("Testbench completed WITH ERRORS");
        else $display("Testbench completed without errors");
        $finish;
    end

endmodule
